// ===== rtl/core/epidemic_sir_marginal_update_unit_assert.svh =====
// assertion macros used by the checker file of the sir marginal update unit
// depends on clk_i and rst_ni being visible where a macro is used
`ifndef EPIDEMIC_SIR_MARGINAL_UPDATE_UNIT_ASSERT_SVH
`define EPIDEMIC_SIR_MARGINAL_UPDATE_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ESMU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("esmu port check failed");

// next-cycle implication, disabled during reset
`define ESMU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("esmu port check failed");

`endif

// ===== rtl/core/esmu_pkg.sv =====
// shared constants, codes and control structs of the sir marginal update unit
// no dependencies
package esmu_pkg;

  localparam int unsigned DEF_MAX_NODES    = 1024;
  localparam int unsigned NODE_COUNT_RESET = 1024;
  localparam int unsigned PROB_W           = 32;
  localparam int unsigned NODE_W           = 10;
  localparam int unsigned COUNT_W          = 11;
  localparam int unsigned PADDR_W          = 4;

  localparam logic [PROB_W-1:0] ONE_Q31 = 32'h8000_0000;

  // item action codes
  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_CONTACT = 2'd1;
  localparam logic [1:0] ACT_CLOSE   = 2'd2;
  localparam logic [1:0] ACT_READ    = 2'd3;

  // register indexes (word address)
  localparam logic [1:0] REG_NODE_COUNT     = 2'd0;
  localparam logic [1:0] REG_INFECTION_RATE = 2'd1;
  localparam logic [1:0] REG_RECOVERY_RATE  = 2'd2;
  localparam logic [1:0] REG_DIRECTED       = 2'd3;

  typedef enum logic [1:0] {
    SEL_CNT,
    SEL_A,
    SEL_B
  } esmu_addr_sel_e;

  typedef enum logic [2:0] {
    WR_CLEAR,
    WR_SEED,
    WR_PROD,
    WR_INF,
    WR_SUSC
  } esmu_wr_mode_e;

  typedef enum logic [2:0] {
    MA_KEEP,
    MA_MULQ,
    MA_SCALE,
    MA_S_RD,
    MA_T0
  } esmu_mul_a_e;

  typedef enum logic [1:0] {
    MB_BETA,
    MB_I_RD,
    MB_P_RD,
    MB_T0
  } esmu_mul_b_e;

  typedef enum logic [1:0] {
    T0_HOLD,
    T0_MSG,
    T0_ONE_MINUS_P
  } esmu_t0_sel_e;

  typedef struct packed {
    logic [PROB_W-1:0] beta_eff;
    logic [PROB_W-1:0] keep;
    logic              directed;
  } esmu_cfg_t;

  typedef struct packed {
    logic           in_ld;
    logic           cnt_clr;
    logic           cnt_inc;
    logic           cnt_all;
    logic           rd_en;
    esmu_addr_sel_e rd_sel;
    logic           wr_en;
    esmu_addr_sel_e wr_sel;
    esmu_wr_mode_e  wr_mode;
    esmu_mul_a_e    mul_a;
    esmu_mul_b_e    mul_b;
    logic           scale_ld;
    esmu_t0_sel_e   t0_sel;
    logic           acc_ld;
    logic           out_ld;
  } esmu_cmd_t;

  typedef struct packed {
    logic a_in_use;
    logic b_in_use;
    logic cnt_last;
    logic directed;
  } esmu_status_t;

endpackage

// ===== rtl/core/esmu_regs.sv =====
// apb register file of the sir marginal update unit
// depends on esmu_pkg; keeps raw values for read-back and clamped copies for the datapath
module esmu_regs #(
  parameter int unsigned MAX_NODES = esmu_pkg::DEF_MAX_NODES
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [esmu_pkg::PADDR_W-1:0]         paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  output esmu_pkg::esmu_cfg_t                  cfg_o,
  output logic [$clog2(MAX_NODES + 1)-1:0]     used_o
);
  import esmu_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_NODES + 1);
  localparam int unsigned UsedReset =
    (NODE_COUNT_RESET > MAX_NODES) ? MAX_NODES : NODE_COUNT_RESET;

  function automatic logic [PROB_W-1:0] clamp_one(logic [PROB_W-1:0] v);
    return (v > ONE_Q31) ? ONE_Q31 : v;
  endfunction

  logic [COUNT_W-1:0] node_count_q;
  logic [PROB_W-1:0]  beta_raw_q;
  logic [PROB_W-1:0]  mu_raw_q;
  logic               directed_q;
  logic [CntW-1:0]    used_q;
  logic [PROB_W-1:0]  beta_eff_q;
  logic [PROB_W-1:0]  keep_q;
  logic               wr_en;
  logic [1:0]         reg_idx;
  logic [COUNT_W-1:0] wr_count;
  logic [CntW-1:0]    used_w;

  assign pready   = 1'b1;
  assign wr_en    = psel & penable & pwrite;
  assign reg_idx  = paddr[3:2];
  assign wr_count = pwdata[COUNT_W-1:0];

  always_comb begin
    if (wr_count == '0) begin
      used_w = CntW'(1);
    end else if (32'(wr_count) > 32'(MAX_NODES)) begin
      used_w = CntW'(MAX_NODES);
    end else begin
      used_w = CntW'(wr_count);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= COUNT_W'(NODE_COUNT_RESET);
      beta_raw_q   <= '0;
      mu_raw_q     <= '0;
      directed_q   <= 1'b0;
      used_q       <= CntW'(UsedReset);
      beta_eff_q   <= '0;
      keep_q       <= ONE_Q31;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_NODE_COUNT: begin
          node_count_q <= wr_count;
          used_q       <= used_w;
        end
        REG_INFECTION_RATE: begin
          beta_raw_q <= pwdata;
          beta_eff_q <= clamp_one(pwdata);
        end
        REG_RECOVERY_RATE: begin
          mu_raw_q <= pwdata;
          keep_q   <= ONE_Q31 - clamp_one(pwdata);
        end
        REG_DIRECTED: begin
          directed_q <= pwdata[0];
        end
        default: begin
          directed_q <= directed_q;
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_NODE_COUNT:     prdata = 32'(node_count_q);
      REG_INFECTION_RATE: prdata = beta_raw_q;
      REG_RECOVERY_RATE:  prdata = mu_raw_q;
      REG_DIRECTED:       prdata = 32'(directed_q);
      default:            prdata = '0;
    endcase
  end

  assign cfg_o.beta_eff = beta_eff_q;
  assign cfg_o.keep     = keep_q;
  assign cfg_o.directed = directed_q;
  assign used_o         = used_q;

endmodule

// ===== rtl/core/esmu_ctrl.sv =====
// sequencer of the sir marginal update unit
// depends on esmu_pkg; drives the datapath through esmu_cmd_t and watches esmu_status_t
module esmu_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [1:0]             action_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  esmu_pkg::esmu_status_t status_i,
  output esmu_pkg::esmu_cmd_t    cmd_o
);
  import esmu_pkg::*;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_CLEAR = 5'd1;
  localparam logic [4:0] ST_SEED  = 5'd2;
  localparam logic [4:0] ST_C0    = 5'd3;
  localparam logic [4:0] ST_C1    = 5'd4;
  localparam logic [4:0] ST_C2    = 5'd5;
  localparam logic [4:0] ST_C3    = 5'd6;
  localparam logic [4:0] ST_C4    = 5'd7;
  localparam logic [4:0] ST_C5    = 5'd8;
  localparam logic [4:0] ST_C6    = 5'd9;
  localparam logic [4:0] ST_C7    = 5'd10;
  localparam logic [4:0] ST_K0    = 5'd11;
  localparam logic [4:0] ST_K1    = 5'd12;
  localparam logic [4:0] ST_K2    = 5'd13;
  localparam logic [4:0] ST_K3    = 5'd14;
  localparam logic [4:0] ST_K4    = 5'd15;
  localparam logic [4:0] ST_R0    = 5'd16;
  localparam logic [4:0] ST_R1    = 5'd17;

  logic [4:0] state_q, state_d;
  logic       seed_q, seed_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  esmu_cmd_t  cmd;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    seed_d  = seed_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.in_ld = 1'b1;
          unique case (action_i)
            ACT_START: begin
              cmd.cnt_clr = 1'b1;
              seed_d      = 1'b1;
              state_d     = ST_CLEAR;
            end
            ACT_CONTACT: state_d = ST_C0;
            ACT_CLOSE: begin
              cmd.cnt_clr = 1'b1;
              state_d     = ST_K0;
            end
            ACT_READ: state_d = ST_R0;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      // whole-store sweep, also the pass after reset
      ST_CLEAR: begin
        cmd.cnt_all = 1'b1;
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = SEL_CNT;
        cmd.wr_mode = WR_CLEAR;
        if (status_i.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_d     = seed_q ? ST_SEED : ST_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_SEED: begin
        cmd.wr_en   = status_i.a_in_use;
        cmd.wr_sel  = SEL_A;
        cmd.wr_mode = WR_SEED;
        seed_d      = 1'b0;
        state_d     = ST_IDLE;
      end
      ST_C0: begin
        if (status_i.a_in_use && status_i.b_in_use) begin
          cmd.mul_a  = MA_KEEP;
          cmd.mul_b  = MB_BETA;
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = SEL_A;
          state_d    = ST_C1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_C1: begin
        cmd.mul_a    = MA_MULQ;
        cmd.mul_b    = MB_I_RD;
        cmd.scale_ld = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = SEL_B;
        state_d      = ST_C2;
      end
      ST_C2: begin
        cmd.mul_a  = MA_SCALE;
        cmd.mul_b  = MB_I_RD;
        cmd.t0_sel = T0_MSG;
        state_d    = ST_C3;
      end
      ST_C3: begin
        cmd.mul_a  = MA_T0;
        cmd.mul_b  = MB_P_RD;
        cmd.t0_sel = T0_MSG;
        state_d    = ST_C4;
      end
      ST_C4: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = SEL_B;
        cmd.wr_mode = WR_PROD;
        state_d     = status_i.directed ? ST_IDLE : ST_C5;
      end
      // receiver product is re-read after its write so a self contact chains
      ST_C5: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = SEL_A;
        state_d    = ST_C6;
      end
      ST_C6: begin
        cmd.mul_a = MA_T0;
        cmd.mul_b = MB_P_RD;
        state_d   = ST_C7;
      end
      ST_C7: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = SEL_A;
        cmd.wr_mode = WR_PROD;
        state_d     = ST_IDLE;
      end
      ST_K0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = SEL_CNT;
        state_d    = ST_K1;
      end
      ST_K1: begin
        cmd.mul_a  = MA_KEEP;
        cmd.mul_b  = MB_I_RD;
        cmd.t0_sel = T0_ONE_MINUS_P;
        state_d    = ST_K2;
      end
      ST_K2: begin
        cmd.mul_a  = MA_S_RD;
        cmd.mul_b  = MB_T0;
        cmd.acc_ld = 1'b1;
        state_d    = ST_K3;
      end
      ST_K3: begin
        cmd.mul_a   = MA_S_RD;
        cmd.mul_b   = MB_P_RD;
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = SEL_CNT;
        cmd.wr_mode = WR_INF;
        state_d     = ST_K4;
      end
      ST_K4: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = SEL_CNT;
        cmd.wr_mode = WR_SUSC;
        if (status_i.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_d     = ST_K0;
        end
      end
      ST_R0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = SEL_A;
        state_d    = ST_R1;
      end
      ST_R1: begin
        if (out_free) begin
          cmd.out_ld = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd.out_ld ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      seed_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seed_q      <= seed_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// ===== rtl/core/esmu_datapath.sv =====
// node stores, shared q1.31 multiplier and result register of the sir marginal update unit
// depends on esmu_pkg; obeys esmu_cmd_t from esmu_ctrl
module esmu_datapath #(
  parameter int unsigned MAX_NODES = esmu_pkg::DEF_MAX_NODES
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  esmu_pkg::esmu_cfg_t                  cfg_i,
  input  logic [$clog2(MAX_NODES + 1)-1:0]     used_i,
  input  logic [esmu_pkg::NODE_W-1:0]          node_a_i,
  input  logic [esmu_pkg::NODE_W-1:0]          node_b_i,
  input  esmu_pkg::esmu_cmd_t                  cmd_i,
  output esmu_pkg::esmu_status_t               status_o,
  output logic [esmu_pkg::NODE_W-1:0]          node_index_o,
  output logic [esmu_pkg::PROB_W-1:0]          prob_susceptible_o,
  output logic [esmu_pkg::PROB_W-1:0]          prob_infected_o,
  output logic [esmu_pkg::PROB_W-1:0]          prob_recovered_o
);
  import esmu_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_NODES);
  localparam int unsigned CntW  = $clog2(MAX_NODES + 1);
  localparam int unsigned ProdW = 2 * PROB_W;
  localparam int unsigned SumW  = PROB_W + 1;

  logic [PROB_W-1:0] s_mem [MAX_NODES];
  logic [PROB_W-1:0] i_mem [MAX_NODES];
  logic [PROB_W-1:0] p_mem [MAX_NODES];

  logic [NODE_W-1:0] node_a_q, node_b_q;
  logic [AddrW-1:0]  k_q;
  logic [PROB_W-1:0] s_rd_q, i_rd_q, p_rd_q;
  logic [PROB_W-1:0] mul_q, scale_q, t0_q, acc_q;
  logic [NODE_W-1:0] out_node_q;
  logic [PROB_W-1:0] out_s_q, out_i_q, out_r_q;

  logic [AddrW-1:0]  addr_a, addr_b, rd_addr, wr_addr;
  logic              s_we, i_we, p_we;
  logic [PROB_W-1:0] s_wdata, i_wdata, p_wdata;
  logic [PROB_W-1:0] mul_a, mul_b;
  logic [ProdW-1:0]  prod_w;
  logic [SumW-1:0]   inf_sum;
  logic [PROB_W-1:0] inf_sat;
  logic              a_in_mem;
  logic [PROB_W-1:0] rd_s, rd_i;
  logic [SumW-1:0]   rd_sum;
  logic [PROB_W-1:0] rd_r;
  logic [CntW-1:0]   cnt_lim;

  assign addr_a = AddrW'(node_a_q);
  assign addr_b = AddrW'(node_b_q);

  always_comb begin
    unique case (cmd_i.rd_sel)
      SEL_CNT: rd_addr = k_q;
      SEL_A:   rd_addr = addr_a;
      SEL_B:   rd_addr = addr_b;
      default: rd_addr = k_q;
    endcase
    unique case (cmd_i.wr_sel)
      SEL_CNT: wr_addr = k_q;
      SEL_A:   wr_addr = addr_a;
      SEL_B:   wr_addr = addr_b;
      default: wr_addr = k_q;
    endcase
  end

  // infected update: keep*i + s*(1-p), saturated at one
  assign inf_sum = SumW'(acc_q) + SumW'(mul_q);
  assign inf_sat = (inf_sum > SumW'(ONE_Q31)) ? ONE_Q31 : inf_sum[PROB_W-1:0];

  always_comb begin
    s_we    = 1'b0;
    i_we    = 1'b0;
    p_we    = 1'b0;
    s_wdata = ONE_Q31;
    i_wdata = '0;
    p_wdata = ONE_Q31;
    unique case (cmd_i.wr_mode)
      WR_CLEAR: begin
        s_we = cmd_i.wr_en;
        i_we = cmd_i.wr_en;
        p_we = cmd_i.wr_en;
      end
      WR_SEED: begin
        s_we    = cmd_i.wr_en;
        i_we    = cmd_i.wr_en;
        s_wdata = '0;
        i_wdata = ONE_Q31;
      end
      WR_PROD: begin
        p_we    = cmd_i.wr_en;
        p_wdata = mul_q;
      end
      WR_INF: begin
        i_we    = cmd_i.wr_en;
        i_wdata = inf_sat;
      end
      WR_SUSC: begin
        s_we    = cmd_i.wr_en;
        p_we    = cmd_i.wr_en;
        s_wdata = mul_q;
      end
      default: begin
        s_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s_we) s_mem[wr_addr] <= s_wdata;
    if (cmd_i.rd_en) s_rd_q <= s_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (i_we) i_mem[wr_addr] <= i_wdata;
    if (cmd_i.rd_en) i_rd_q <= i_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (p_we) p_mem[wr_addr] <= p_wdata;
    if (cmd_i.rd_en) p_rd_q <= p_mem[rd_addr];
  end

  always_comb begin
    case (cmd_i.mul_a)
      MA_KEEP:  mul_a = cfg_i.keep;
      MA_MULQ:  mul_a = mul_q;
      MA_SCALE: mul_a = scale_q;
      MA_S_RD:  mul_a = s_rd_q;
      MA_T0:    mul_a = t0_q;
      default:  mul_a = '0;
    endcase
    case (cmd_i.mul_b)
      MB_BETA: mul_b = cfg_i.beta_eff;
      MB_I_RD: mul_b = i_rd_q;
      MB_P_RD: mul_b = p_rd_q;
      MB_T0:   mul_b = t0_q;
      default: mul_b = '0;
    endcase
  end

  // q1.31 product, truncated
  assign prod_w = ProdW'(mul_a) * ProdW'(mul_b);

  always_ff @(posedge clk_i) begin
    mul_q <= prod_w[ProdW-2:PROB_W-1];
    if (cmd_i.scale_ld) scale_q <= mul_q;
    if (cmd_i.acc_ld) acc_q <= mul_q;
    case (cmd_i.t0_sel)
      T0_MSG:         t0_q <= ONE_Q31 - mul_q;
      T0_ONE_MINUS_P: t0_q <= ONE_Q31 - p_rd_q;
      default:        t0_q <= t0_q;
    endcase
    if (cmd_i.in_ld) begin
      node_a_q <= node_a_i;
      node_b_q <= node_b_i;
    end
  end

  assign cnt_lim = cmd_i.cnt_all ? CntW'(MAX_NODES) : used_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      k_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      k_q <= k_q + AddrW'(1);
    end
  end

  // read result: entries beyond the store read as zero
  assign a_in_mem = 32'(node_a_q) < 32'(MAX_NODES);
  assign rd_s     = a_in_mem ? s_rd_q : '0;
  assign rd_i     = a_in_mem ? i_rd_q : '0;
  assign rd_sum   = SumW'(rd_s) + SumW'(rd_i);
  assign rd_r     = (rd_sum >= SumW'(ONE_Q31)) ? '0 : (ONE_Q31 - rd_sum[PROB_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_node_q <= node_a_q;
      out_s_q    <= rd_s;
      out_i_q    <= rd_i;
      out_r_q    <= rd_r;
    end
  end

  assign status_o.a_in_use = 32'(node_a_q) < 32'(used_i);
  assign status_o.b_in_use = 32'(node_b_q) < 32'(used_i);
  assign status_o.cnt_last = (32'(k_q) + 32'd1) == 32'(cnt_lim);
  assign status_o.directed = cfg_i.directed;

  assign node_index_o       = out_node_q;
  assign prob_susceptible_o = out_s_q;
  assign prob_infected_o    = out_i_q;
  assign prob_recovered_o   = out_r_q;

endmodule

// ===== rtl/core/epidemic_sir_marginal_update_unit.sv =====
// top level of the sir marginal update unit: apb registers, sequencer and datapath
// depends on esmu_pkg, esmu_regs, esmu_ctrl and esmu_datapath
//
// Keeps per-node susceptible, infected and incoming-product probabilities
// (unsigned q1.31, 1.0 = 0x8000_0000) in three single-port-write stores of
// MAX_NODES words, all driven through one shared 32x32 multiplier. One item
// is worked at a time; in_stall_o is low only while the sequencer is idle,
// and a read result waits in its own output register so the next item can be
// taken while it is held. A contact multiplies the sender's message into the
// receiver's product, and the reverse too when undirected; it is dropped
// when a node is out of use. A close step walks the nodes in use with five
// multiplier/store steps per node; a read waits while the previous result
// is still held; a start rewrites every entry of all three stores, one word
// per cycle, then seeds node a when it is in use. After reset the same
// clearing pass runs before the first item is taken; register writes are taken at any time.
module epidemic_sir_marginal_update_unit #(
  parameter int unsigned MAX_NODES = esmu_pkg::DEF_MAX_NODES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [esmu_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // input items
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   action_i,
  input  logic [esmu_pkg::NODE_W-1:0]  node_a_i,
  input  logic [esmu_pkg::NODE_W-1:0]  node_b_i,
  // result items
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [esmu_pkg::NODE_W-1:0]  node_index_o,
  output logic [esmu_pkg::PROB_W-1:0]  prob_susceptible_o,
  output logic [esmu_pkg::PROB_W-1:0]  prob_infected_o,
  output logic [esmu_pkg::PROB_W-1:0]  prob_recovered_o
);
  import esmu_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_NODES + 1);

  esmu_cfg_t    cfg;
  esmu_cmd_t    cmd;
  esmu_status_t status;
  logic [CntW-1:0] used;

  // registers hold clamped rates and the node count already limited to the store
  esmu_regs #(
    .MAX_NODES (MAX_NODES)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .used_o  (used)
  );

  // sequencer: clearing pass and seed, contact, close-step walk and read
  esmu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (action_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // stores, multiplier and result register
  esmu_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .used_i             (used),
    .node_a_i           (node_a_i),
    .node_b_i           (node_b_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .node_index_o       (node_index_o),
    .prob_susceptible_o (prob_susceptible_o),
    .prob_infected_o    (prob_infected_o),
    .prob_recovered_o   (prob_recovered_o)
  );

endmodule

// ===== rtl/core/esmu_checker.sv =====
// port-level checks of the sir marginal update unit, bound to the top level
// depends on esmu_pkg and epidemic_sir_marginal_update_unit_assert.svh
`include "epidemic_sir_marginal_update_unit_assert.svh"

module esmu_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [esmu_pkg::NODE_W-1:0]  node_index_o,
  input logic [esmu_pkg::PROB_W-1:0]  prob_susceptible_o,
  input logic [esmu_pkg::PROB_W-1:0]  prob_infected_o,
  input logic [esmu_pkg::PROB_W-1:0]  prob_recovered_o
);
  import esmu_pkg::*;

  logic [PROB_W:0] out_sum;
  logic [PROB_W:0] out_total;

  assign out_sum   = (PROB_W + 1)'(prob_susceptible_o) + (PROB_W + 1)'(prob_infected_o);
  assign out_total = out_sum + (PROB_W + 1)'(prob_recovered_o);

  // a held result does not move
  `ESMU_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(node_index_o) && $stable(prob_susceptible_o) && $stable(prob_infected_o) && $stable(prob_recovered_o))

  // every item keeps the block busy for at least the next cycle
  `ESMU_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // a new result only comes out of a busy block
  `ESMU_ASSERT_IMP(a_result_from_work, $rose(out_valid_o), $past(in_stall_o))

  // recovered closes the sum to one, or is zero when the other two reach it
  `ESMU_ASSERT_IMP(a_recovered_sum, out_valid_o, ((out_sum >= (PROB_W + 1)'(ONE_Q31)) && (prob_recovered_o == '0)) || ((out_sum < (PROB_W + 1)'(ONE_Q31)) && (out_total == (PROB_W + 1)'(ONE_Q31))))

endmodule

bind epidemic_sir_marginal_update_unit esmu_checker u_esmu_checker (.*);

// ===== tb/epidemic_sir_marginal_update_unit_tb.sv =====
`timescale 1ns / 1ps
// testbench of the sir marginal update unit: directed and random items, every read checked
// against a predictor of the per-node probabilities kept here
// depends on esmu_pkg and epidemic_sir_marginal_update_unit
module epidemic_sir_marginal_update_unit_tb;
  import esmu_pkg::*;

  localparam int unsigned MAX_NODES   = DEF_MAX_NODES;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // long receiver hold-off, in cycles
  localparam int unsigned HOLD_LEN    = 400;
  // mismatches printed in full
  localparam int unsigned SHOWN_MAX   = 10;

  // settings swept by the extreme-settings test: count 0 and 2047 fold to 1 and MAX_NODES,
  // rates above 1.0 fold to 1.0
  localparam int unsigned EXT_N = 6;
  localparam logic [31:0] EXT_COUNT [EXT_N] = '{0, 1, 2047, 1024, 2, 5};
  localparam logic [31:0] EXT_BETA  [EXT_N] = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h0,
                                                 32'h8000_0001, 32'h3A5C_91E7, 32'h1};
  localparam logic [31:0] EXT_MU    [EXT_N] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000,
                                                 32'h7FFF_FFFF, 32'h1, 32'h8000_0001};
  localparam logic [31:0] EXT_DIR   [EXT_N] = '{0, 1, 0, 1, 1, 0};

  // one read report as the block returns it
  typedef struct packed {
    logic [NODE_W-1:0] idx;
    logic [PROB_W-1:0] susc;
    logic [PROB_W-1:0] inf;
    logic [PROB_W-1:0] rec;
  } node_report_t;

  // clock, reset and configuration port
  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;

  // item input channel
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        action_i   = ACT_READ;
  logic [NODE_W-1:0] node_a_i   = '0;
  logic [NODE_W-1:0] node_b_i   = '0;

  // item output channel
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [NODE_W-1:0] node_index_o;
  logic [PROB_W-1:0] prob_susceptible_o;
  logic [PROB_W-1:0] prob_infected_o;
  logic [PROB_W-1:0] prob_recovered_o;

  // predicted node state and register copies
  logic [PROB_W-1:0]  susc_q [MAX_NODES];
  logic [PROB_W-1:0]  inf_q  [MAX_NODES];
  logic [PROB_W-1:0]  prod_q [MAX_NODES];
  logic [COUNT_W-1:0] cfg_count    = COUNT_W'(NODE_COUNT_RESET);
  logic [PROB_W-1:0]  cfg_beta     = '0;
  logic [PROB_W-1:0]  cfg_mu       = '0;
  logic               cfg_directed = 1'b0;

  // reads accepted whose report has not come back yet, oldest first
  node_report_t reports_due [$];

  int unsigned mismatch_count = 0;
  int unsigned items_applied  = 0;
  int unsigned cycle_count    = 0;

  // idling: percent chance per item (sender) and per cycle (receiver)
  int unsigned send_gap_pct = 10;
  int unsigned recv_gap_pct = 77;
  // long hold-off request, counted out by the stall process
  logic        long_hold    = 1'b0;
  int unsigned held_cycles  = 0;

  epidemic_sir_marginal_update_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .action_i           (action_i),
    .node_a_i           (node_a_i),
    .node_b_i           (node_b_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .node_index_o       (node_index_o),
    .prob_susceptible_o (prob_susceptible_o),
    .prob_infected_o    (prob_infected_o),
    .prob_recovered_o   (prob_recovered_o)
  );

  initial forever #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // q1.31 product, truncated toward zero
  function automatic logic [PROB_W-1:0] q_mul(input logic [PROB_W-1:0] x,
                                               input logic [PROB_W-1:0] y);
    logic [63:0] full;
    full = 64'(x) * 64'(y);
    return full[62:31];
  endfunction

  function automatic logic [PROB_W-1:0] cap_one(input logic [PROB_W-1:0] v);
    return (v > ONE_Q31) ? ONE_Q31 : v;
  endfunction

  // node count register folded into 1..MAX_NODES
  function automatic int unsigned nodes_in_use();
    if (cfg_count == 0) return 1;
    if (cfg_count > MAX_NODES) return MAX_NODES;
    return 32'(cfg_count);
  endfunction

  // 1 - mu
  function automatic logic [PROB_W-1:0] survive_factor();
    return ONE_Q31 - cap_one(cfg_mu);
  endfunction

  // what a sender passes on: 1 - (1-mu)*beta*infected, infected as last stored
  function automatic logic [PROB_W-1:0] contact_message(input int unsigned node);
    return ONE_Q31 - q_mul(q_mul(survive_factor(), cap_one(cfg_beta)), inf_q[node]);
  endfunction

  function automatic void clear_nodes();
    for (int k = 0; k < MAX_NODES; k++) begin
      susc_q[k] = ONE_Q31;
      inf_q[k]  = '0;
      prod_q[k] = ONE_Q31;
    end
  endfunction

  // applies one accepted item to the predicted state, queues the report of a read
  function automatic void advance_marginals(input logic [1:0] act,
                                            input logic [NODE_W-1:0] a,
                                            input logic [NODE_W-1:0] b);
    int unsigned       used;
    logic [PROB_W-1:0] msg_a, msg_b, keep;
    logic [PROB_W:0]   sum;
    node_report_t      rep;
    used = nodes_in_use();
    case (act)
      ACT_START: begin
        // a seed out of use leaves every node cleared and none infected
        clear_nodes();
        if (a < used) begin
          susc_q[a] = '0;
          inf_q[a]  = ONE_Q31;
        end
      end
      ACT_CONTACT: begin
        // any node out of use drops the whole contact
        if (a < used && b < used) begin
          msg_a = contact_message(a);
          msg_b = contact_message(b);
          prod_q[b] = q_mul(prod_q[b], msg_a);
          // self contact: the reverse direction sees the product just updated
          if (!cfg_directed) prod_q[a] = q_mul(prod_q[a], msg_b);
        end
      end
      ACT_CLOSE: begin
        keep = survive_factor();
        for (int unsigned k = 0; k < used; k++) begin
          sum = {1'b0, q_mul(keep, inf_q[k])} + {1'b0, q_mul(susc_q[k], ONE_Q31 - prod_q[k])};
          inf_q[k]  = (sum > {1'b0, ONE_Q31}) ? ONE_Q31 : sum[PROB_W-1:0];
          susc_q[k] = q_mul(susc_q[k], prod_q[k]);
          prod_q[k] = ONE_Q31;
        end
      end
      ACT_READ: begin
        // nodes out of use report whatever their entry holds
        sum      = {1'b0, susc_q[a]} + {1'b0, inf_q[a]};
        rep.idx  = a;
        rep.susc = susc_q[a];
        rep.inf  = inf_q[a];
        rep.rec  = (sum >= {1'b0, ONE_Q31}) ? '0 : ONE_Q31 - sum[PROB_W-1:0];
        reports_due.push_back(rep);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // checking, receiver stalls and watchdog
  // ---------------------------------------------------------------------------

  function automatic void note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= SHOWN_MAX) $display("mismatch: %s", what);
  endfunction

  // every accepted report is compared with the oldest read still due
  always @(posedge clk_i) begin : check_reports
    node_report_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (reports_due.size() == 0) begin
        note_mismatch($sformatf("report for node %0d with no read due", node_index_o));
      end else begin
        want = reports_due.pop_front();
        if (node_index_o !== want.idx || prob_susceptible_o !== want.susc ||
            prob_infected_o !== want.inf || prob_recovered_o !== want.rec)
          note_mismatch($sformatf(
            "expected node %0d s=%h i=%h r=%h, got node %0d s=%h i=%h r=%h",
            want.idx, want.susc, want.inf, want.rec, node_index_o,
            prob_susceptible_o, prob_infected_o, prob_recovered_o));
      end
    end
  end

  // receiver: a long hold-off when asked, random stalls otherwise
  always @(posedge clk_i) begin
    if (long_hold && held_cycles < HOLD_LEN) begin
      out_stall_i <= 1'b1;
      held_cycles <= held_cycles + 1;
    end else begin
      if (!long_hold) held_cycles <= 0;
      out_stall_i <= ($urandom_range(99) < recv_gap_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // shared stimulus tasks, all entered and left just after a rising edge
  // ---------------------------------------------------------------------------

  // offers one item, waits for it to be taken, then predicts it
  task automatic send_item(input logic [1:0] act, input logic [NODE_W-1:0] a,
                           input logic [NODE_W-1:0] b);
    int unsigned used;
    used = nodes_in_use();
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    node_a_i   <= a;
    node_b_i   <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    advance_marginals(act, a, b);
    // ignored contacts do not count as work done
    if (!(act == ACT_CONTACT && (a >= used || b >= used))) items_applied++;
  endtask

  // drops valid and waits until every due read has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (reports_due.size() != 0);
  endtask

  // drained, then enough cycles for a close step or a start still being walked
  task automatic settle_block();
    wait_drained();
    repeat (5 * nodes_in_use() + MAX_NODES + 64) @(posedge clk_i);
  endtask

  // apb write, then a read back of the same register
  task automatic program_register(input logic [1:0] reg_idx, input logic [31:0] value);
    logic [31:0] kept;
    case (reg_idx)
      REG_NODE_COUNT: kept = 32'(value[COUNT_W-1:0]);
      REG_DIRECTED:   kept = 32'(value[0]);
      default:        kept = value;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({reg_idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // written at this edge, read setup follows with psel held
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== kept)
      note_mismatch($sformatf("register %0d read back %h, expected %h", reg_idx, prdata, kept));
    psel    <= 1'b0;
    penable <= 1'b0;
    // bus left idle before the next transfer
    @(posedge clk_i);
    case (reg_idx)
      REG_NODE_COUNT:     cfg_count    = value[COUNT_W-1:0];
      REG_INFECTION_RATE: cfg_beta     = value;
      REG_RECOVERY_RATE:  cfg_mu       = value;
      REG_DIRECTED:       cfg_directed = value[0];
    endcase
  endtask

  // mostly nodes in use, sometimes anywhere in the field range
  function automatic logic [NODE_W-1:0] pick_node(input int unsigned used);
    if ($urandom_range(99) < 85) return NODE_W'($urandom_range(used - 1));
    return NODE_W'($urandom);
  endfunction

  // rates weighted toward 1.0, above 1.0 and tiny values
  function automatic logic [31:0] draw_rate();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 20) return ONE_Q31;
    if (roll < 30) return $urandom | ONE_Q31;
    if (roll < 40) return $urandom_range(255);
    return $urandom_range(ONE_Q31);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked items on eight nodes: seeding, contacts in and out of use,
  // self contact, field extremes, reads of nodes out of use
  task automatic test_directed_cases();
    program_register(REG_NODE_COUNT, 32'd8);
    program_register(REG_INFECTION_RATE, ONE_Q31);
    program_register(REG_RECOVERY_RATE, 32'h2000_0000);
    program_register(REG_DIRECTED, 32'd0);
    send_item(ACT_START, 10'd3, 10'd0);
    send_item(ACT_READ, 10'd3, 10'd0);
    send_item(ACT_CONTACT, 10'd3, 10'd5);
    send_item(ACT_CONTACT, 10'd5, 10'd5);
    send_item(ACT_CONTACT, 10'd3, 10'd9);
    send_item(ACT_CONTACT, 10'd1023, 10'd0);
    send_item(ACT_CONTACT, 10'd0, 10'd3);
    send_item(ACT_CLOSE, 10'd0, 10'd0);
    send_item(ACT_READ, 10'd5, 10'd0);
    send_item(ACT_READ, 10'd0, 10'd0);
    send_item(ACT_READ, 10'd1023, 10'd0);
    send_item(ACT_CONTACT, 10'd5, 10'd0);
    send_item(ACT_CONTACT, 10'd0, 10'd1023);
    send_item(ACT_CLOSE, 10'd1023, 10'd1023);
    send_item(ACT_READ, 10'd5, 10'd1023);
    send_item(ACT_READ, 10'd3, 10'd0);
    // seed out of use: all cleared, nobody infected
    send_item(ACT_START, 10'd1023, 10'd0);
    send_item(ACT_READ, 10'd3, 10'd0);
    send_item(ACT_START, 10'd7, 10'd1023);
    send_item(ACT_CONTACT, 10'd7, 10'd0);
    send_item(ACT_CLOSE, 10'd0, 10'd0);
    send_item(ACT_READ, 10'd0, 10'd0);
  endtask

  // short outbreak under each extreme setting, count and rates out of range included
  task automatic test_extreme_settings();
    for (int k = 0; k < EXT_N; k++) begin
      settle_block();
      program_register(REG_NODE_COUNT, EXT_COUNT[k]);
      program_register(REG_INFECTION_RATE, EXT_BETA[k]);
      program_register(REG_RECOVERY_RATE, EXT_MU[k]);
      program_register(REG_DIRECTED, EXT_DIR[k]);
      send_item(ACT_START, 10'd0, 10'd1023);
      send_item(ACT_CONTACT, 10'd0, 10'd1);
      send_item(ACT_CONTACT, 10'd0, 10'd0);
      send_item(ACT_CONTACT, 10'd1, 10'd0);
      send_item(ACT_CLOSE, 10'd0, 10'd0);
      send_item(ACT_READ, 10'd0, 10'd0);
      send_item(ACT_READ, 10'd1, 10'd0);
      send_item(ACT_CONTACT, 10'd1, 10'd0);
      send_item(ACT_CLOSE, 10'd0, 10'd0);
      send_item(ACT_READ, 10'd1, 10'd0);
      send_item(ACT_READ, 10'd0, 10'd0);
    end
  endtask

  // receiver holds off while reads keep coming, so the block backs up its input
  task automatic test_output_backpressure();
    int unsigned used;
    used = nodes_in_use();
    long_hold <= 1'b1;
    for (int k = 0; k < 12; k++)
      send_item((k % 4 == 3) ? ACT_CONTACT : ACT_READ, pick_node(used), pick_node(used));
    wait_drained();
    long_hold <= 1'b0;
  endtask

  // sender goes quiet until every report is back, then carries on
  task automatic test_pause_until_drained();
    send_item(ACT_START, 10'd1, 10'd0);
    send_item(ACT_CONTACT, 10'd1, 10'd0);
    send_item(ACT_READ, 10'd1, 10'd0);
    wait_drained();
    send_item(ACT_CLOSE, 10'd0, 10'd0);
    send_item(ACT_READ, 10'd0, 10'd0);
    wait_drained();
    send_item(ACT_READ, 10'd1, 10'd0);
  endtask

  // outbreaks with random content under random settings, in three idling modes
  task automatic test_random_episodes();
    int unsigned       send_pct [3] = '{10, 77, 0};
    int unsigned       recv_pct [3] = '{77, 10, 0};
    int unsigned       used, target, roll;
    logic [31:0]       count_val;
    logic [NODE_W-1:0] a, b;
    for (int m = 0; m < 3; m++) begin
      send_gap_pct = send_pct[m];
      recv_gap_pct <= recv_pct[m];
      for (int ph = 0; ph < 4; ph++) begin
        settle_block();
        // mostly small networks, now and then large or out of range
        roll = $urandom_range(99);
        if (roll < 75)      count_val = $urandom_range(48, 2);
        else if (roll < 95) count_val = $urandom_range(256, 49);
        else                count_val = $urandom_range(2047);
        program_register(REG_NODE_COUNT, count_val);
        program_register(REG_INFECTION_RATE, draw_rate());
        program_register(REG_RECOVERY_RATE, draw_rate());
        program_register(REG_DIRECTED, 32'($urandom_range(1)));
        used   = nodes_in_use();
        target = items_applied + 45;
        send_item(ACT_START, NODE_W'($urandom_range(used - 1)), NODE_W'($urandom));
        while (items_applied < target) begin
          roll = $urandom_range(99);
          a    = pick_node(used);
          b    = pick_node(used);
          if (roll < 3)       send_item(ACT_START, a, b);
          else if (roll < 58) send_item(ACT_CONTACT, a, b);
          else if (roll < 70) send_item(ACT_CLOSE, a, b);
          else if (roll < 97) send_item(ACT_READ, a, b);
          else begin
            // occasional quiet spell until all reports are in
            wait_drained();
            send_item(ACT_READ, a, b);
          end
        end
      end
    end
  endtask

  initial begin
    clear_nodes();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_extreme_settings();
    test_output_backpressure();
    test_pause_until_drained();
    test_random_episodes();
    settle_block();
    if (mismatch_count == 0 && reports_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/esmu_pkg.sv
rtl/core/esmu_regs.sv
rtl/core/esmu_ctrl.sv
rtl/core/esmu_datapath.sv
rtl/core/epidemic_sir_marginal_update_unit.sv
rtl/core/esmu_checker.sv
tb/epidemic_sir_marginal_update_unit_tb.sv
